// ----- rtl/sfls_pkg.sv -----
// Shared types, constants and helpers for the substring first/last search unit.
package sfls_pkg;

  localparam int unsigned NEEDLE_REGS_W = 64;
  localparam int unsigned LEN_W         = 5;
  localparam int unsigned POS_W         = 16;
  localparam int unsigned IN_TDATA_W    = 8;
  localparam int unsigned OUT_TDATA_W   = 40;
  localparam int unsigned CFG_ADDR_W    = 5;
  localparam int unsigned CFG_DATA_W    = 64;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Register index, taken from paddr[4:3]
  typedef enum logic [1:0] {
    REG_NEEDLE_LOW  = 2'd0,
    REG_NEEDLE_HIGH = 2'd1,
    REG_NEEDLE_LEN  = 2'd2
  } cfg_reg_t;

  typedef logic [7:0] byte_t;

  // Pick needle byte k (0..15) out of the two needle registers.
  function automatic byte_t needle_byte(input logic [NEEDLE_REGS_W-1:0] lo,
                                        input logic [NEEDLE_REGS_W-1:0] hi,
                                        input logic [3:0] k);
    byte_t b;
    if (k[3] == 1'b0) begin
      b = lo[{k[2:0], 3'b000} +: 8];
    end else begin
      b = hi[{k[2:0], 3'b000} +: 8];
    end
    return b;
  endfunction

endpackage

// ----- rtl/substring_first_last_search_unit.sv -----
// Streaming substring search reporting the first and last match start of each text.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------------
//  s_*     | in  | s_tvalid / s_tready    | s_tdata[7:0] text_byte, s_tlast last_byte
//  m_*     | out | m_tvalid / m_tready    | m_tdata: found, first pos, found, last pos,
//          |     |                        |          too_long (see port comment)
//  APB     | in  | psel/penable, pready=1 | needle low @0x00, high @0x08, length @0x10
//
// One text byte is taken per cycle, back to back, but for the stall below. A byte
// is registered on acceptance, then compared and folded into the per-text state;
// the result for the last byte of a text enters the output register as it is folded.
// The only stall is a last byte whose result meets a full, unread output register:
// the input register then holds and s_tready drops. Synchronous reset clears the
// needle registers, the window, the counters and both valid flags.
module substring_first_last_search_unit
  import sfls_pkg::*;
#(
  parameter int unsigned MAX_NEEDLE = 16,
  parameter int unsigned MAX_TEXT   = 65536
) (
  input  logic                   clk,
  input  logic                   rst,
  // text input
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] text_byte
  input  logic                   s_tlast,   // last_byte
  // result output
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [0] first_found, [16:1] first_position,
                                            // [17] last_found, [33:18] last_position,
                                            // [34] text_too_long, [39:35] zero
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]  prdata,
  output logic                   pready
);

  // Byte counter holds 0..MAX_TEXT; start arithmetic is done at least 17 bits wide
  // so that saturation to 16 bits is visible.
  localparam int unsigned PW = $clog2(MAX_TEXT + 1);
  localparam int unsigned SW = (PW > POS_W) ? PW : POS_W + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [NEEDLE_REGS_W-1:0] needle_low;
  logic [NEEDLE_REGS_W-1:0] needle_high;
  logic [LEN_W-1:0]         needle_len;
  logic                     cfg_write;
  cfg_reg_t                 cfg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_sel   = cfg_reg_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      needle_low  <= '0;
      needle_high <= '0;
      needle_len  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        REG_NEEDLE_LOW:  needle_low  <= pwdata;
        REG_NEEDLE_HIGH: needle_high <= pwdata;
        REG_NEEDLE_LEN:  needle_len  <= pwdata[LEN_W-1:0];
        default: ; // unmapped address: drop the write
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_NEEDLE_LOW:  prdata = needle_low;
      REG_NEEDLE_HIGH: prdata = needle_high;
      REG_NEEDLE_LEN:  prdata = CFG_DATA_W'(needle_len);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic  st_valid;
  byte_t st_byte;
  logic  st_last;
  logic  st_adv;

  // A non-final byte never waits; a final one needs room in the output register.
  assign st_adv   = st_valid && (!st_last || !m_tvalid || m_tready);
  assign s_tready = !st_valid || st_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (s_tready) begin
      st_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      st_byte <= s_tdata[7:0];
      st_last <= s_tlast;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-text state: byte window, position counter, match record
  // ---------------------------------------------------------------------------
  byte_t [MAX_NEEDLE-1:0] window;
  byte_t [MAX_NEEDLE-1:0] window_next;
  logic [PW-1:0]          pos;
  logic [PW-1:0]          pos_next;
  logic                   seen_match;
  logic                   seen_next;
  logic [POS_W-1:0]       earliest;
  logic [POS_W-1:0]       earliest_next;
  logic [POS_W-1:0]       latest;
  logic [POS_W-1:0]       latest_next;
  logic                   overflow;
  logic                   overflow_next;

  logic [PW-1:0]          count;
  logic                   len_ok;
  logic [MAX_NEEDLE-1:0]  byte_eq;
  logic                   window_hit;
  logic [SW-1:0]          start_wide;
  logic [POS_W-1:0]       start_pos;

  // Shift the new byte in at index 0; the oldest byte falls off the top.
  always_comb begin
    window_next[0] = st_byte;
    for (int j = 1; j < MAX_NEEDLE; j++) begin
      window_next[j] = window[j-1];
    end
  end

  // Window index j lines up with needle byte len-1-j; indices at or above the
  // length take no part in the compare.
  always_comb begin
    for (int j = 0; j < MAX_NEEDLE; j++) begin
      if (LEN_W'(j) < needle_len) begin
        byte_eq[j] = (window_next[j] ==
                      needle_byte(needle_low, needle_high,
                                  4'(needle_len - LEN_W'(1) - LEN_W'(j))));
      end else begin
        byte_eq[j] = 1'b1;
      end
    end
  end

  assign count      = pos + PW'(1);
  assign len_ok     = (needle_len != '0) && (needle_len <= LEN_W'(MAX_NEEDLE));
  assign window_hit = len_ok && (count >= PW'(needle_len)) && (&byte_eq);
  assign start_wide = SW'(count) - SW'(needle_len);
  assign start_pos  = (start_wide > SW'(POS_MAX)) ? POS_MAX : start_wide[POS_W-1:0];

  always_comb begin
    pos_next      = pos;
    seen_next     = seen_match;
    earliest_next = earliest;
    latest_next   = latest;
    overflow_next = overflow;
    if (pos >= PW'(MAX_TEXT)) begin
      // past the length limit: flag it, hold the count, record nothing
      overflow_next = 1'b1;
    end else begin
      pos_next = count;
      if (window_hit) begin
        if (!seen_match) begin
          earliest_next = start_pos;
        end
        latest_next = start_pos;
        seen_next   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= '0;
      pos        <= '0;
      seen_match <= 1'b0;
      earliest   <= '0;
      latest     <= '0;
      overflow   <= 1'b0;
    end else if (st_adv) begin
      if (st_last) begin
        // end of text: start the next one from a clean slate
        window     <= '0;
        pos        <= '0;
        seen_match <= 1'b0;
        earliest   <= '0;
        latest     <= '0;
        overflow   <= 1'b0;
      end else begin
        window     <= window_next;
        pos        <= pos_next;
        seen_match <= seen_next;
        earliest   <= earliest_next;
        latest     <= latest_next;
        overflow   <= overflow_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic             res_found;
  logic [POS_W-1:0] res_first;
  logic [POS_W-1:0] res_last;

  // An empty needle always matches at index 0.
  assign res_found = seen_next || (needle_len == '0);
  assign res_first = (seen_next && needle_len != '0) ? earliest_next : '0;
  assign res_last  = (seen_next && needle_len != '0) ? latest_next : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (st_adv && st_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_adv && st_last) begin
      m_tdata <= OUT_TDATA_W'({overflow_next, res_last, res_found, res_first, res_found});
    end
  end

`ifndef SYNTHESIS
  a_pos_bounded: assert property (@(posedge clk) disable iff (rst)
    pos <= PW'(MAX_TEXT))
    else $error("byte counter ran past the text limit");

  a_no_match_clean: assert property (@(posedge clk) disable iff (rst)
    !seen_match |-> (earliest == '0) && (latest == '0))
    else $error("match record set without a match");

  a_mid_text_no_stall: assert property (@(posedge clk) disable iff (rst)
    st_valid && !st_last |-> s_tready)
    else $error("non-final byte stalled the input");

  a_found_agree: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == m_tdata[17]))
    else $error("forward and reverse found flags disagree");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> (m_tdata[16:1] == '0) && (m_tdata[33:18] == '0))
    else $error("positions non-zero on a miss");

  a_result_follows_last: assert property (@(posedge clk) disable iff (rst)
    st_adv && st_last |=> m_tvalid)
    else $error("final byte produced no result");
`endif

endmodule

// ----- tb/sv/substring_first_last_search_unit_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the streaming substring first/last search unit.
module substring_first_last_search_unit_tb;
  import sfls_pkg::*;

  localparam int unsigned NEEDLE_MAX  = 16;
  localparam int unsigned TEXT_MAX    = 65536;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned SETTLE_CYCLES = 4;
  // Index 3 has no register behind it: writes there must leave the needle alone
  localparam logic [CFG_ADDR_W-1:0] UNUSED_REG_ADDR = 5'h18;

  // Result fields, highest bit first, as they sit in m_tdata
  typedef struct packed {
    logic             too_long;
    logic [POS_W-1:0] last_pos;
    logic             last_found;
    logic [POS_W-1:0] first_pos;
    logic             first_found;
  } search_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;    // [7:0] text_byte
  logic                   s_tlast = 1'b0;  // last_byte
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;         // [0] first_found, [16:1] first_position,
                                           // [17] last_found, [33:18] last_position,
                                           // [34] text_too_long, [39:35] zero
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  paddr = '0;
  logic [CFG_DATA_W-1:0]  pwdata = '0;
  logic [CFG_DATA_W-1:0]  prdata;
  logic                   pready;

  substring_first_last_search_unit #(
    .MAX_NEEDLE (NEEDLE_MAX),
    .MAX_TEXT   (TEXT_MAX)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Idling percentages, changed per phase by the test tasks
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  // Needle as last programmed, used to seed occurrences into the stimulus
  byte_t       stim_needle [NEEDLE_MAX];
  int unsigned stim_len = 0;

  int unsigned fail_count = 0;

  // ---------------------------------------------------------------------------
  // Search predictor: register copies plus per-text state
  // ---------------------------------------------------------------------------
  logic [NEEDLE_REGS_W-1:0] cfg_low  = '0;
  logic [NEEDLE_REGS_W-1:0] cfg_high = '0;
  logic [LEN_W-1:0]         cfg_len  = '0;

  byte_t       window [NEEDLE_MAX];
  int unsigned bytes_seen;
  bit          seen_match;
  int unsigned earliest_start;
  int unsigned latest_start;
  bit          text_overflow;

  search_result_t expected_results [$];

  function automatic void clear_text_state();
    foreach (window[i]) window[i] = '0;
    bytes_seen     = 0;
    seen_match     = 1'b0;
    earliest_start = 0;
    latest_start   = 0;
    text_overflow  = 1'b0;
  endfunction

  function automatic byte_t needle_at(input int unsigned k);
    if (k < 8) return cfg_low[8*k +: 8];
    return cfg_high[8*(k-8) +: 8];
  endfunction

  // Fold one accepted text byte into the search state; on the last byte of a
  // text queue the result it must produce.
  function automatic void search_step(input byte_t b, input logic last);
    int unsigned    len;
    int unsigned    count;
    int unsigned    start;
    bit             hit;
    bit             found;
    search_result_t res;
    len = cfg_len;
    for (int i = NEEDLE_MAX - 1; i > 0; i--) window[i] = window[i-1];
    window[0] = b;
    if (bytes_seen >= TEXT_MAX) begin
      // Past the maximum: flag it and record nothing ending here
      text_overflow = 1'b1;
    end else begin
      count = bytes_seen + 1;
      hit   = (len > 0) && (len <= NEEDLE_MAX) && (count >= len);
      if (hit) begin
        // Newest byte closes the occurrence, so needle byte k sits len-1-k back
        for (int k = 0; k < len; k++) begin
          if (window[len-1-k] != needle_at(k)) hit = 1'b0;
        end
      end
      if (hit) begin
        start = count - len;
        if (start > 16'hFFFF) start = 16'hFFFF;
        if (!seen_match) earliest_start = start;
        latest_start = start;
        seen_match   = 1'b1;
      end
      bytes_seen = count;
    end
    if (last) begin
      // An empty needle matches at index 0 whatever the text
      found = seen_match || (len == 0);
      res.first_found = found;
      res.first_pos   = (found && len != 0) ? earliest_start[POS_W-1:0] : '0;
      res.last_found  = found;
      res.last_pos    = (found && len != 0) ? latest_start[POS_W-1:0] : '0;
      res.too_long    = text_overflow;
      expected_results.push_back(res);
      clear_text_state();
    end
  endfunction

  initial clear_text_state();

  // Track every register write and every accepted text byte at the edge
  always @(posedge clk) begin
    if (rst) begin
      cfg_low  = '0;
      cfg_high = '0;
      cfg_len  = '0;
      clear_text_state();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_t'(paddr[4:3]))
          REG_NEEDLE_LOW:  cfg_low  = pwdata;
          REG_NEEDLE_HIGH: cfg_high = pwdata;
          REG_NEEDLE_LEN:  cfg_len  = pwdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) search_step(s_tdata, s_tlast);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  function automatic void note_failure(input string msg);
    if (fail_count < 10) $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) note_failure($sformatf("%s expected %0d, got %0d", name, want, got));
  endfunction

  always @(posedge clk) begin
    search_result_t got;
    search_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = search_result_t'(m_tdata[34:0]);
      if (expected_results.size() == 0) begin
        note_failure($sformatf("result 0x%h with none outstanding", m_tdata));
      end else begin
        want = expected_results.pop_front();
        check_field("first_found", 32'(want.first_found), 32'(got.first_found));
        check_field("first_position", 32'(want.first_pos), 32'(got.first_pos));
        check_field("last_found", 32'(want.last_found), 32'(got.last_found));
        check_field("last_position", 32'(want.last_pos), 32'(got.last_pos));
        check_field("text_too_long", 32'(want.too_long), 32'(got.too_long));
        check_field("padding", 0, 32'(m_tdata[OUT_TDATA_W-1:35]));
      end
    end
  end

  // Receiver: drop tready at random for the stall percentage of the phase
  always @(posedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  // Watchdog: end the run if it hangs
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("substring_first_last_search_unit_tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [CFG_ADDR_W-1:0] reg_addr(input cfg_reg_t r);
    return {r, 3'b000};
  endfunction

  // One register write: setup cycle, access cycle, then an idle cycle so that
  // back-to-back writes never raise and lower psel in the same step
  task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Pack the needle and write all three registers
  task automatic program_needle(input byte_t nb [NEEDLE_MAX], input int unsigned len);
    logic [NEEDLE_REGS_W-1:0] lo;
    logic [NEEDLE_REGS_W-1:0] hi;
    for (int k = 0; k < 8; k++) begin
      lo[8*k +: 8] = nb[k];
      hi[8*k +: 8] = nb[k+8];
    end
    stim_needle = nb;
    stim_len    = len;
    apb_write(reg_addr(REG_NEEDLE_LOW), lo);
    apb_write(reg_addr(REG_NEEDLE_HIGH), hi);
    apb_write(reg_addr(REG_NEEDLE_LEN), CFG_DATA_W'(len));
  endtask

  // Offer one byte, idling beforehand at the sender's rate; hold until taken
  task automatic send_text_byte(input byte_t b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_text(input byte_t txt [$]);
    foreach (txt[i]) send_text_byte(txt[i], i == txt.size() - 1);
  endtask

  // Stop sending and wait for every outstanding result, then let the
  // pipeline settle before any register write
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Needle length is zero out of reset: any text matches at index 0
  task automatic test_empty_needle_after_reset();
    byte_t txt [$];
    txt = '{8'h5C};
    send_text(txt);
    drain_results();
  endtask

  // One-byte needle of 0xFF: occurrences at 1 and at the final byte
  task automatic test_character_search();
    byte_t nb [NEEDLE_MAX];
    byte_t txt [$];
    foreach (nb[k]) nb[k] = 8'hFF;
    program_needle(nb, 1);
    txt = '{8'h00, 8'hFF, 8'h12, 8'hFF};
    send_text(txt);
    drain_results();
  endtask

  // Full 16-byte needle equal to the whole text: both searches land on index 0
  task automatic test_full_needle();
    byte_t nb [NEEDLE_MAX];
    byte_t txt [$];
    nb = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'hC3, 8'h3C, 8'h81, 8'h7E,
           8'h08, 8'h80, 8'h04, 8'h40, 8'h02, 8'h20, 8'h10, 8'h01};
    program_needle(nb, NEEDLE_MAX);
    foreach (nb[k]) txt.push_back(nb[k]);
    send_text(txt);
    drain_results();
  endtask

  // Needle longer than the text, then a length beyond the maximum: not found.
  // A write to the unused address in between must change nothing.
  task automatic test_needle_longer_than_text();
    byte_t txt [$];
    txt = '{stim_needle[0], stim_needle[1], stim_needle[2]};
    send_text(txt);
    drain_results();
    apb_write(UNUSED_REG_ADDR, '1);
    apb_write(reg_addr(REG_NEEDLE_LEN), CFG_DATA_W'(17));
    txt = '{stim_needle[0], stim_needle[1]};
    send_text(txt);
    drain_results();
    apb_write(reg_addr(REG_NEEDLE_LEN), CFG_DATA_W'(31));
    stim_len = 31;
  endtask

  // Random texts with a new needle every few texts. Most texts carry whole or
  // partial copies of the needle; a narrow alphabet forces overlapping and
  // near-miss occurrences.
  task automatic test_random_texts(input int unsigned n_bytes, input int unsigned tx_idle,
                                   input int unsigned rx_idle);
    byte_t       nb [NEEDLE_MAX];
    byte_t       txt [$];
    byte_t       base;
    bit          narrow;
    int unsigned sent;
    int unsigned text_no;
    int unsigned tl;
    int unsigned r;
    int unsigned len;
    int unsigned piece;
    send_idle_pct = tx_idle;
    stall_pct     = rx_idle;
    sent    = 0;
    text_no = 0;
    while (sent < n_bytes) begin
      if (text_no % 5 == 0) begin
        drain_results();
        narrow = ($urandom_range(1) == 1);
        base   = byte_t'($urandom_range(255));
        foreach (nb[k]) begin
          nb[k] = narrow ? byte_t'(base + $urandom_range(1)) : byte_t'($urandom_range(255));
        end
        r = $urandom_range(99);
        if (r < 8)       len = 0;
        else if (r < 16) len = NEEDLE_MAX;
        else if (r < 20) len = $urandom_range(31, 17);
        else if (r < 85) len = $urandom_range(4, 1);
        else             len = $urandom_range(15, 5);
        program_needle(nb, len);
      end
      tl = ($urandom_range(99) < 90) ? $urandom_range(24, 1) : $urandom_range(80, 25);
      txt.delete();
      while (txt.size() < tl) begin
        r = $urandom_range(99);
        if (stim_len != 0 && r < 30) begin
          // Mostly a complete occurrence, sometimes a broken prefix
          piece = (stim_len > NEEDLE_MAX) ? NEEDLE_MAX : stim_len;
          if (r >= 22) piece = $urandom_range(piece, 1);
          for (int k = 0; k < piece; k++) txt.push_back(stim_needle[k]);
        end else begin
          txt.push_back(narrow ? byte_t'(base + $urandom_range(1))
                               : byte_t'($urandom_range(255)));
        end
      end
      while (txt.size() > tl) void'(txt.pop_back());
      send_text(txt);
      sent += tl;
      text_no++;
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_needle_after_reset();
    test_character_search();
    test_full_needle();
    test_needle_longer_than_text();
    test_random_texts(640, 9, 87);
    test_random_texts(640, 87, 9);
    test_random_texts(640, 0, 0);

    drain_results();
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_results.size()));
    if (fail_count == 0) begin
      $display("substring_first_last_search_unit_tb: PASS");
    end else begin
      $display("substring_first_last_search_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
